### sv/laubb_pkg.sv
package laubb_pkg;

  // Angle units are 1/16 degree, so one full turn is 360 degrees
  localparam int unsigned FULL_TURN = 5760;
  localparam int unsigned TURN_BITS = 8;

  localparam int unsigned ANGLE_W  = 13;
  localparam int unsigned WINDOW_W = 12;
  localparam int unsigned SPEED_W  = 16;
  localparam int unsigned DUTY_W   = 17;
  localparam int unsigned TOTAL_W  = 21;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ADDR_W   = 5;

  // Ten degrees past the load point sends the idle rule back
  localparam int unsigned TEN_DEG   = FULL_TURN / 36;
  localparam int unsigned SPEED_MAX = 32768;

  localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
  localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};

  typedef logic [ANGLE_W-1:0] angle_t;

  // Register index (byte address divided by four)
  typedef enum logic [2:0] {
    REG_UNLOAD_POINT  = 3'd0,
    REG_MIDDLE_POINT  = 3'd1,
    REG_LOAD_POINT    = 3'd2,
    REG_TRIGGER_POINT = 3'd3,
    REG_WRAP_WINDOW   = 3'd4,
    REG_ZERO_OFFSET   = 3'd5,
    REG_TOP_SPEED     = 3'd6
  } reg_idx_t;

  typedef struct packed {
    angle_t                unload_point;
    angle_t                middle_point;
    angle_t                load_point;
    angle_t                trigger_point;
    logic [WINDOW_W-1:0]   wrap_window;
    angle_t                zero_offset;
    logic [SPEED_W-1:0]    top_speed;
  } cfg_t;

  // Mode requests of one item
  typedef struct packed {
    logic enabled;
    logic fire_req;
    logic load_req;
    logic trigger_req;
    logic purge_req;
  } req_t;

endpackage

### sv/laubb_cfg.sv
module laubb_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [laubb_pkg::ADDR_W-1:0]  paddr,
  input  logic [laubb_pkg::DATA_W-1:0]  pwdata,
  output logic [laubb_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  output laubb_pkg::cfg_t               cfg
);

  laubb_pkg::reg_idx_t idx;
  logic                wr_en;

  assign idx    = laubb_pkg::reg_idx_t'(paddr[laubb_pkg::ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Write the addressed register on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.unload_point  <= laubb_pkg::ANGLE_W'(80);
      cfg.middle_point  <= laubb_pkg::ANGLE_W'(2880);
      cfg.load_point    <= laubb_pkg::ANGLE_W'(5600);
      cfg.trigger_point <= laubb_pkg::ANGLE_W'(5760);
      cfg.wrap_window   <= laubb_pkg::WINDOW_W'(320);
      cfg.zero_offset   <= '0;
      cfg.top_speed     <= laubb_pkg::SPEED_W'(laubb_pkg::SPEED_MAX);
    end else if (wr_en) begin
      unique case (idx)
        laubb_pkg::REG_UNLOAD_POINT:  cfg.unload_point  <= pwdata[laubb_pkg::ANGLE_W-1:0];
        laubb_pkg::REG_MIDDLE_POINT:  cfg.middle_point  <= pwdata[laubb_pkg::ANGLE_W-1:0];
        laubb_pkg::REG_LOAD_POINT:    cfg.load_point    <= pwdata[laubb_pkg::ANGLE_W-1:0];
        laubb_pkg::REG_TRIGGER_POINT: cfg.trigger_point <= pwdata[laubb_pkg::ANGLE_W-1:0];
        laubb_pkg::REG_WRAP_WINDOW:   cfg.wrap_window   <= pwdata[laubb_pkg::WINDOW_W-1:0];
        laubb_pkg::REG_ZERO_OFFSET:   cfg.zero_offset   <= pwdata[laubb_pkg::ANGLE_W-1:0];
        laubb_pkg::REG_TOP_SPEED:     cfg.top_speed     <= pwdata[laubb_pkg::SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    prdata = '0;
    unique case (idx)
      laubb_pkg::REG_UNLOAD_POINT:  prdata = laubb_pkg::DATA_W'(cfg.unload_point);
      laubb_pkg::REG_MIDDLE_POINT:  prdata = laubb_pkg::DATA_W'(cfg.middle_point);
      laubb_pkg::REG_LOAD_POINT:    prdata = laubb_pkg::DATA_W'(cfg.load_point);
      laubb_pkg::REG_TRIGGER_POINT: prdata = laubb_pkg::DATA_W'(cfg.trigger_point);
      laubb_pkg::REG_WRAP_WINDOW:   prdata = laubb_pkg::DATA_W'(cfg.wrap_window);
      laubb_pkg::REG_ZERO_OFFSET:   prdata = laubb_pkg::DATA_W'(cfg.zero_offset);
      laubb_pkg::REG_TOP_SPEED:     prdata = laubb_pkg::DATA_W'(cfg.top_speed);
      default:                      prdata = '0;
    endcase
  end

endmodule

### sv/laubb_unwrap.sv
module laubb_unwrap (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  advance,
  input  laubb_pkg::angle_t                     sensor_angle,
  input  laubb_pkg::cfg_t                       cfg,
  output laubb_pkg::angle_t                     cur_angle,
  output logic signed [laubb_pkg::TURN_BITS-1:0] turns_next,
  output logic signed [laubb_pkg::TOTAL_W-1:0]  total_next
);

  localparam int unsigned DIFF_W = laubb_pkg::ANGLE_W + 3;

  laubb_pkg::angle_t                      prev_angle;
  logic signed [laubb_pkg::TURN_BITS-1:0] turns;
  logic                                   primed;

  logic signed [DIFF_W-1:0]            diff0, diff1, diff2;
  laubb_pkg::angle_t                   window;
  laubb_pkg::angle_t                   high_edge;
  logic                                cross_up, cross_down;
  logic signed [laubb_pkg::TOTAL_W-1:0] turn_ext, turn_span;

  // Invert, take off the zero offset, then fold back into one turn
  always_comb begin
    diff0 = $signed(DIFF_W'(laubb_pkg::FULL_TURN)) - $signed(DIFF_W'(sensor_angle))
            - $signed(DIFF_W'(cfg.zero_offset));
    diff1 = diff0[DIFF_W-1] ? diff0 + $signed(DIFF_W'(laubb_pkg::FULL_TURN)) : diff0;
    diff2 = diff1[DIFF_W-1] ? diff1 + $signed(DIFF_W'(laubb_pkg::FULL_TURN)) : diff1;
  end

  assign cur_angle = diff2[laubb_pkg::ANGLE_W-1:0];

  // Detect a jump across the wrap point
  assign window     = laubb_pkg::ANGLE_W'(cfg.wrap_window);
  assign high_edge  = laubb_pkg::ANGLE_W'(laubb_pkg::FULL_TURN) - window;
  assign cross_up   = primed && (cur_angle < window) && (prev_angle > high_edge);
  assign cross_down = primed && !cross_up && (cur_angle > high_edge) && (prev_angle < window);

  // Saturating turn count
  always_comb begin
    turns_next = turns;
    if (cross_up && (turns != laubb_pkg::TURN_MAX)) begin
      turns_next = turns + 1'b1;
    end else if (cross_down && (turns != laubb_pkg::TURN_MIN)) begin
      turns_next = turns - 1'b1;
    end
  end

  assign turn_ext   = laubb_pkg::TOTAL_W'(turns_next);
  assign turn_span  = turn_ext * $signed(laubb_pkg::TOTAL_W'(laubb_pkg::FULL_TURN));
  assign total_next = turn_span + $signed(laubb_pkg::TOTAL_W'(cur_angle));

  // Advance tracking state once per transfer into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_angle <= '0;
      turns      <= '0;
      primed     <= 1'b0;
    end else if (advance) begin
      prev_angle <= cur_angle;
      turns      <= turns_next;
      primed     <= 1'b1;
    end
  end

endmodule

### sv/laubb_drive.sv
module laubb_drive (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 advance,
  input  laubb_pkg::req_t                      req,
  input  laubb_pkg::angle_t                    cur_angle,
  input  laubb_pkg::cfg_t                      cfg,
  output logic signed [laubb_pkg::DUTY_W-1:0]  duty_next,
  output logic                                 done_next,
  output logic                                 safety_next
);

  logic                                done_reg;
  logic signed [laubb_pkg::DUTY_W-1:0] speed_pos, speed_neg;
  logic [laubb_pkg::ANGLE_W:0]         back_point;

  // Clamp the speed to full scale
  assign speed_pos = (cfg.top_speed > laubb_pkg::SPEED_W'(laubb_pkg::SPEED_MAX))
                     ? $signed(laubb_pkg::DUTY_W'(laubb_pkg::SPEED_MAX))
                     : $signed(laubb_pkg::DUTY_W'(cfg.top_speed));
  assign speed_neg  = -speed_pos;
  assign back_point = (laubb_pkg::ANGLE_W+1)'(cfg.load_point)
                      + (laubb_pkg::ANGLE_W+1)'(laubb_pkg::TEN_DEG);

  // Pick the duty by mode priority
  always_comb begin
    duty_next = '0;
    if (req.enabled) begin
      if (req.fire_req) begin
        duty_next = speed_pos;
      end else if (req.load_req) begin
        duty_next = (cur_angle < cfg.load_point) ? speed_pos : '0;
      end else if (req.trigger_req) begin
        duty_next = (cur_angle < cfg.trigger_point) ? speed_pos : '0;
      end else if (req.purge_req) begin
        duty_next = (cur_angle > cfg.unload_point) ? speed_neg : '0;
      end else if ((cur_angle != '0) && (cur_angle < cfg.middle_point)) begin
        duty_next = speed_pos;
      end else if ((laubb_pkg::ANGLE_W+1)'(cur_angle) > back_point) begin
        duty_next = speed_neg;
      end
    end
  end

  // Hold done while disabled; while enabled, fire clears it
  assign done_next   = req.enabled ? ((duty_next == '0) && !req.fire_req) : done_reg;
  assign safety_next = req.enabled;

  always_ff @(posedge clk) begin
    if (rst) begin
      done_reg <= 1'b0;
    end else if (advance) begin
      done_reg <= done_next;
    end
  end

endmodule

### sv/loader_angle_unwrap_bang_bang_core.sv
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   sensor_angle, enabled, fire_req, load_req,
//                                         trigger_req, purge_req
// out      output     out_valid/out_stall motor_duty, done_flag, safety_on,
//                                         wrapped_angle, turn_count, total_angle
// cfg      input      APB psel/penable    paddr, pwdata, prdata, pready
//
// One item per cycle sustained while out_stall stays low; a result passes from its transfer in
// through the input register, then the result register with the unwrap and duty logic between.
// Reset (rst, synchronous) clears the turn count, last angle, done flag and the
// registers to their defaults; the first item after reset only primes the last angle.
// A stalled result holds; one more item waits in the input register, then in_stall rises.
module loader_angle_unwrap_bang_bang_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  laubb_pkg::angle_t                     sensor_angle,
  input  logic                                  enabled,
  input  logic                                  fire_req,
  input  logic                                  load_req,
  input  logic                                  trigger_req,
  input  logic                                  purge_req,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [laubb_pkg::DUTY_W-1:0]   motor_duty,
  output logic                                  done_flag,
  output logic                                  safety_on,
  output laubb_pkg::angle_t                     wrapped_angle,
  output logic signed [laubb_pkg::TURN_BITS-1:0] turn_count,
  output logic signed [laubb_pkg::TOTAL_W-1:0]  total_angle,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [laubb_pkg::ADDR_W-1:0]          paddr,
  input  logic [laubb_pkg::DATA_W-1:0]          pwdata,
  output logic [laubb_pkg::DATA_W-1:0]          prdata,
  output logic                                  pready
);

  laubb_pkg::cfg_t   cfg;
  logic              s1_valid;
  laubb_pkg::angle_t s1_angle;
  laubb_pkg::req_t   s1_req;
  logic              accept;
  logic              advance;

  laubb_pkg::angle_t                      cur_angle;
  logic signed [laubb_pkg::TURN_BITS-1:0] turns_next;
  logic signed [laubb_pkg::TOTAL_W-1:0]   total_next;
  logic signed [laubb_pkg::DUTY_W-1:0]    duty_next;
  logic                                   done_next;
  logic                                   safety_next;

  laubb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Move the input register forward whenever the result register is free or draining
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Capture the item on transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_angle           <= sensor_angle;
      s1_req.enabled     <= enabled;
      s1_req.fire_req    <= fire_req;
      s1_req.load_req    <= load_req;
      s1_req.trigger_req <= trigger_req;
      s1_req.purge_req   <= purge_req;
    end
  end

  laubb_unwrap u_unwrap (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .sensor_angle (s1_angle),
    .cfg          (cfg),
    .cur_angle    (cur_angle),
    .turns_next   (turns_next),
    .total_next   (total_next)
  );

  laubb_drive u_drive (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .req         (s1_req),
    .cur_angle   (cur_angle),
    .cfg         (cfg),
    .duty_next   (duty_next),
    .done_next   (done_next),
    .safety_next (safety_next)
  );

  // Result register: fill on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      motor_duty    <= duty_next;
      done_flag     <= done_next;
      safety_on     <= safety_next;
      wrapped_angle <= cur_angle;
      turn_count    <= turns_next;
      total_angle   <= total_next;
    end
  end

endmodule
